// ===== rtl/core/ffa_pkg.sv =====
// ============================================================================
// ffa_pkg: shared types for the first-fit free-region allocator
// Request and result payload structs, request and status codes and rounding constants.
// ============================================================================
package ffa_pkg;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_LOST = 1'b1;

    localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
    localparam logic [31:0] ROUND_MASK = 32'hffff_f000;

    typedef struct packed {
        logic        req_type;
        logic [31:0] region_addr;
        logic [31:0] region_size;
        logic        round_4k;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_addr;
        logic        status;
        logic [31:0] total_free;
        logic [10:0] entries_used;
        logic [10:0] entries_peak;
        logic [31:0] lost_count;
        logic [31:0] lost_bytes;
    } rsp_t;

endpackage

// ===== rtl/core/ffa_table_ram.sv =====
// ============================================================================
// ffa_table_ram: free-region table storage
// One write port and one registered read port; each word holds a region's
// start address and length.
// ============================================================================
module ffa_table_ram
#(
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [63:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [63:0]       rd_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/first_fit_free_list_allocator_top.sv =====
// ============================================================================
// first_fit_free_list_allocator_top: first-fit allocator with coalescing
// Sorted free-region table in one RAM, walked by a small sequencer.
// ============================================================================
// One request is processed at a time; ready is low while it runs. The table
// sits in a single-port-read, single-port-write RAM with a registered read:
// an allocate scans up to N entries and, if a region empties, shifts the tail
// down; a release scans for its position and then merges, shifts the tail
// down after a merge with both neighbors or shifts the tail up to insert.
// Scan and shift together cover the table once for N used entries. No
// clearing pass after reset.
module first_fit_free_list_allocator_top
    import ffa_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_ARD     = 10'b00_0000_0010,
        ST_ACHK    = 10'b00_0000_0100,
        ST_SHRD    = 10'b00_0000_1000,
        ST_SHWR    = 10'b00_0001_0000,
        ST_RRD     = 10'b00_0010_0000,
        ST_RCHK    = 10'b00_0100_0000,
        ST_RNEXT   = 10'b00_1000_0000,
        ST_INSRD   = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] addr_reg, size_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, peak_reg;
    logic [31:0] total_reg, lostc_reg, lostb_reg;
    logic [31:0] got_reg;
    logic        stat_reg;
    logic        prev_ok_reg;
    logic [63:0] prev_reg;
    logic [63:0] carry_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [63:0]   wr_data, rd_data;

    ffa_table_ram #(.ADDR_W(AW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic [31:0] size_in;
    logic [31:0] rd_start, rd_len;
    assign size_in  = in_data.round_4k ? ((in_data.region_size + ROUND_ADD) & ROUND_MASK)
                                       : in_data.region_size;
    assign rd_start = rd_data[63:32];
    assign rd_len   = rd_data[31:0];
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    // The insert walk reads one entry ahead so that each displaced entry is
    // in hand before its slot is overwritten.
    assign rd_addr   = ((state_reg == ST_RNEXT) || (state_reg == ST_INSRD))
                       ? idx_next[AW-1:0] : idx_reg[AW-1:0];

    // Control and datapath of the table sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = 64'd0;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid && in_ready)
                begin
                    state_next = (in_data.req_type == REQ_RELEASE) ? ST_RRD : ST_ARD;
                end
            end
            ST_ARD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ACHK;
                end
            end
            ST_ACHK:
            begin
                if (rd_len >= size_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = {rd_start + size_reg, rd_len - size_reg};
                    if (rd_len == size_reg)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ARD;
                end
            end
            ST_SHRD:
            begin
                // Shift down: read entry idx, write it to idx-1. The count is
                // already reduced, so the last entry to move sits at count.
                if (idx_reg == count_reg + 1'b1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SHWR;
                end
            end
            ST_SHWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(idx_reg - 1'b1);
                wr_data    = rd_data;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SHRD;
            end
            ST_RRD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_RNEXT;
                end
                else
                begin
                    state_next = ST_RCHK;
                end
            end
            ST_RCHK:
            begin
                if (rd_start > addr_reg)
                begin
                    state_next = ST_RNEXT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RRD;
                end
            end
            ST_RNEXT:
            begin
                // idx = first entry above addr; rd_data valid if idx < count.
                if (prev_ok_reg && (prev_reg[63:32] + prev_reg[31:0] == addr_reg))
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - 1'b1);
                    if (idx_reg < count_reg && (addr_reg + size_reg == rd_start))
                    begin
                        wr_data    = {prev_reg[63:32], prev_reg[31:0] + size_reg + rd_len};
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        wr_data    = {prev_reg[63:32], prev_reg[31:0] + size_reg};
                        state_next = ST_DONE;
                    end
                end
                else if (idx_reg < count_reg && (addr_reg + size_reg == rd_start))
                begin
                    wr_en      = 1'b1;
                    wr_data    = {addr_reg, rd_len + size_reg};
                    state_next = ST_DONE;
                end
                else if (count_reg < CW'(TABLE_ENTRIES))
                begin
                    // Insert: write new entry, carry old ones upward.
                    wr_en      = 1'b1;
                    wr_data    = {addr_reg, size_reg};
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg == count_reg) ? ST_DONE : ST_INSRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_INSRD:
            begin
                // carry holds the displaced entry; rd_data is the one at idx.
                // The count already includes the new entry, so the last
                // displaced entry lands at count-1.
                wr_en    = 1'b1;
                wr_data  = carry_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            total_reg     <= '0;
            lostc_reg     <= '0;
            lostb_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        addr_reg    <= in_data.region_addr;
                        size_reg    <= size_in;
                        got_reg     <= '0;
                        stat_reg    <= STATUS_DONE;
                        prev_ok_reg <= 1'b0;
                    end
                end
                ST_ACHK:
                begin
                    if (rd_len >= size_reg)
                    begin
                        got_reg   <= rd_start;
                        total_reg <= total_reg - size_reg;
                        if (rd_len == size_reg)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                ST_RCHK:
                begin
                    if (!(rd_start > addr_reg))
                    begin
                        prev_ok_reg <= 1'b1;
                        prev_reg    <= rd_data;
                    end
                end
                ST_RNEXT:
                begin
                    carry_reg <= rd_data;
                    if (prev_ok_reg && (prev_reg[63:32] + prev_reg[31:0] == addr_reg))
                    begin
                        total_reg <= total_reg + size_reg;
                        if (idx_reg < count_reg && (addr_reg + size_reg == rd_start))
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                    else if (idx_reg < count_reg && (addr_reg + size_reg == rd_start))
                    begin
                        total_reg <= total_reg + size_reg;
                    end
                    else if (count_reg < CW'(TABLE_ENTRIES))
                    begin
                        total_reg <= total_reg + size_reg;
                        count_reg <= count_reg + 1'b1;
                        if (peak_reg < count_reg + 1'b1)
                        begin
                            peak_reg <= count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        stat_reg  <= STATUS_LOST;
                        lostc_reg <= lostc_reg + 1'b1;
                        lostb_reg <= lostb_reg + size_reg;
                    end
                end
                ST_INSRD:
                begin
                    carry_reg <= rd_data;
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            out_reg.alloc_addr   <= got_reg;
            out_reg.status       <= stat_reg;
            out_reg.total_free   <= total_reg;
            out_reg.entries_used <= 11'(count_reg);
            out_reg.entries_peak <= 11'(peak_reg);
            out_reg.lost_count   <= lostc_reg;
            out_reg.lost_bytes   <= lostb_reg;
        end
    end

endmodule
